// ----- src/rvct_pkg.sv -----
`default_nettype none
package rvct_pkg;

  // Field widths of the item ports.
  localparam int POS_W = 10;
  localparam int VAL_W = 10;
  localparam int OCC_W = 11;

  // Default geometry of the table.
  localparam int DEF_POSITIONS  = 1024;
  localparam int DEF_BLOCK_SIZE = 32;
  localparam int DEF_NUM_BLOCKS = 32;
  localparam int DEF_VALUE_IDS  = 1024;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_SCAN,
    ST_RESULT,
    ST_UPD_RDOLD,
    ST_UPD_WROLD,
    ST_UPD_RDNEW,
    ST_UPD_WRNEW
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic clear_step;
    logic div_step;
    logic scan_step;
    logic sel_old;
    logic wr_old;
    logic wr_new;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic is_query;
    logic bad;
    logic empty;
    logic upd_skip;
    logic div_last;
    logic scan_done;
  } status_t;

endpackage
`default_nettype wire

// ----- src/range_value_count_table_top.sv -----
// Range value count table. Pulse start while busy is low to hand in one item:
// mode 0 writes in_value_id at in_first_pos, mode 1 counts how many occupied
// positions from in_first_pos to in_last_pos hold in_value_id. A query gives
// exactly one result, shown for a single cycle with out_valid high; the
// receiver cannot stall it, so it must take the result in that cycle. An
// update gives no result. After reset the block sweeps its count memory and
// its position marks to zero, one entry a cycle, over max(VALUE_IDS *
// NUM_BLOCKS, POSITIONS) entries (32768 at the defaults) and holds busy high
// meanwhile. An update keeps busy high through a check step, two division
// steps by BLOCK_SIZE (a reciprocal multiply for the block, then the offset
// inside it) and four memory steps; one at a position past the table or with
// an out-of-range value id ends after the check. A query passes the check and
// the division, then walks the range, one step per scanned entry of the
// partial end blocks plus one per whole block between them, as each memory
// has a single read port; it then strobes its result and drops busy right
// after. A reversed or empty range skips from the check to the result strobe.
`default_nettype none
module range_value_count_table_top #(
  parameter int POSITIONS  = rvct_pkg::DEF_POSITIONS,
  parameter int BLOCK_SIZE = rvct_pkg::DEF_BLOCK_SIZE,
  parameter int NUM_BLOCKS = rvct_pkg::DEF_NUM_BLOCKS,
  parameter int VALUE_IDS  = rvct_pkg::DEF_VALUE_IDS
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       in_mode,
  input  wire logic [rvct_pkg::POS_W-1:0] in_first_pos,
  input  wire logic [rvct_pkg::POS_W-1:0] in_last_pos,
  input  wire logic [rvct_pkg::VAL_W-1:0] in_value_id,
  output logic                            out_valid,
  output logic [rvct_pkg::OCC_W-1:0]      out_occurrences,
  output logic                            out_bad_range
);

  rvct_pkg::cmd_t    cmd;
  rvct_pkg::status_t status;

  // The controller sequences clearing, division, range walk and update steps.
  rvct_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .status       (status),
    .cmd          (cmd),
    .busy         (busy),
    .result_valid (out_valid)
  );

  // The datapath holds both memories, the divider and the accumulator.
  rvct_datapath #(
    .POSITIONS  (POSITIONS),
    .BLOCK_SIZE (BLOCK_SIZE),
    .NUM_BLOCKS (NUM_BLOCKS),
    .VALUE_IDS  (VALUE_IDS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mode      (in_mode),
    .in_first_pos (in_first_pos),
    .in_last_pos  (in_last_pos),
    .in_value_id  (in_value_id),
    .cmd          (cmd),
    .status       (status),
    .occurrences  (out_occurrences),
    .bad_range    (out_bad_range)
  );

endmodule
`default_nettype wire

// ----- src/rvct_datapath.sv -----
`default_nettype none
module rvct_datapath #(
  parameter int POSITIONS  = rvct_pkg::DEF_POSITIONS,
  parameter int BLOCK_SIZE = rvct_pkg::DEF_BLOCK_SIZE,
  parameter int NUM_BLOCKS = rvct_pkg::DEF_NUM_BLOCKS,
  parameter int VALUE_IDS  = rvct_pkg::DEF_VALUE_IDS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_mode,
  input  wire logic [rvct_pkg::POS_W-1:0]  in_first_pos,
  input  wire logic [rvct_pkg::POS_W-1:0]  in_last_pos,
  input  wire logic [rvct_pkg::VAL_W-1:0]  in_value_id,
  input  wire rvct_pkg::cmd_t              cmd,
  output rvct_pkg::status_t                status,
  output logic [rvct_pkg::OCC_W-1:0]       occurrences,
  output logic                             bad_range
);

  localparam int POS_W     = rvct_pkg::POS_W;
  localparam int VAL_W     = rvct_pkg::VAL_W;
  localparam int OCC_W     = rvct_pkg::OCC_W;
  localparam int PW        = $clog2(POSITIONS);
  localparam int PRW       = ((PW > POS_W) ? PW : POS_W) + 1;
  localparam int SPAN      = NUM_BLOCKS * BLOCK_SIZE;
  localparam int LIMIT     = (POSITIONS < SPAN) ? POSITIONS : SPAN;
  localparam int BW        = $clog2(NUM_BLOCKS);
  localparam int CW        = $clog2(BLOCK_SIZE + 1);
  localparam int RW        = $clog2(BLOCK_SIZE) + 1;
  localparam int SW        = PRW + RW;
  localparam int CNT_DEPTH = VALUE_IDS * NUM_BLOCKS;
  localparam int CAW       = $clog2(CNT_DEPTH);
  localparam int CLR_LEN   = (CNT_DEPTH > POSITIONS) ? CNT_DEPTH : POSITIONS;
  localparam int CLW       = $clog2(CLR_LEN);
  localparam int VS_W      = VAL_W + 1;
  // Block index by reciprocal multiplication: exact for every POS_W-bit position.
  localparam int DL        = $clog2(BLOCK_SIZE);
  localparam int DS        = POS_W + DL;
  localparam int PDW       = DS + POS_W;
  localparam int RECIP     = ((1 << DS) + BLOCK_SIZE - 1) / BLOCK_SIZE;

  // Position store: top bit marks the position occupied.
  logic [VS_W-1:0] vs_mem [POSITIONS];
  logic [CW-1:0]   cnt_mem [CNT_DEPTH];

  logic             mode_r, bad_r, empty_r, skip_r;
  logic [PRW-1:0]   pos_r, lim_r;
  logic [VAL_W-1:0] val_r;
  logic [POS_W-1:0] dvd_r, q_r;
  logic [RW-1:0]    rem_r;
  logic             div_cnt_r;
  logic [CLW-1:0]   clr_r;
  logic [OCC_W-1:0] acc_r;
  logic             pend_entry_r, pend_blk_r;
  logic [VS_W-1:0]  vs_rd_r;
  logic [CW-1:0]    cnt_rd_r;

  logic [PRW-1:0]   first_x, last_x, lim_x;
  logic             v_ok;
  logic [PDW-1:0]   q_prod;
  logic [POS_W-1:0] q_div;
  logic [POS_W-1:0] rem_full;
  logic             whole;
  logic             done;
  logic [VAL_W-1:0] cnt_val;
  logic [CAW-1:0]   cnt_addr, cnt_waddr;
  logic             cnt_we;
  logic [CW-1:0]    cnt_wdata;
  logic             vs_we;
  logic [PW-1:0]    vs_idx, vs_waddr;
  logic [VS_W-1:0]  vs_wdata;
  logic             clr_cnt_ok, clr_vs_ok;

  assign first_x = PRW'(in_first_pos);
  assign last_x  = PRW'(in_last_pos);
  assign lim_x   = (last_x >= PRW'(LIMIT)) ? PRW'(LIMIT - 1) : last_x;
  assign v_ok    = 32'(in_value_id) < VALUE_IDS;

  assign q_prod   = PDW'(dvd_r) * PDW'(RECIP);
  assign q_div    = q_prod[PDW-1:DS];
  assign rem_full = dvd_r - POS_W'(q_r * POS_W'(BLOCK_SIZE));

  assign done  = pos_r > lim_r;
  assign whole = (rem_r == '0) && (SW'(pos_r) + SW'(BLOCK_SIZE - 1) <= SW'(lim_r));

  assign clr_cnt_ok = 32'(clr_r) < CNT_DEPTH;
  assign clr_vs_ok  = 32'(clr_r) < POSITIONS;

  assign vs_idx   = pos_r[PW-1:0];
  assign cnt_val  = cmd.sel_old ? vs_rd_r[VAL_W-1:0] : val_r;
  assign cnt_addr = CAW'(cnt_val) * CAW'(NUM_BLOCKS) + CAW'(q_r[BW-1:0]);

  assign cnt_we    = (cmd.clear_step && clr_cnt_ok)
                   || (cmd.wr_old && vs_rd_r[VAL_W] && (cnt_rd_r != '0))
                   || cmd.wr_new;
  assign cnt_waddr = cmd.clear_step ? clr_r[CAW-1:0] : cnt_addr;
  assign cnt_wdata = cmd.clear_step ? '0 :
                     cmd.wr_old     ? cnt_rd_r - CW'(1) : cnt_rd_r + CW'(1);

  assign vs_we    = (cmd.clear_step && clr_vs_ok) || cmd.wr_new;
  assign vs_waddr = cmd.clear_step ? clr_r[PW-1:0] : vs_idx;
  assign vs_wdata = cmd.clear_step ? '0 : {1'b1, val_r};

  always_ff @(posedge clk) begin
    if (vs_we) begin
      vs_mem[vs_waddr] <= vs_wdata;
    end
    vs_rd_r <= vs_mem[vs_idx];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rd_r <= cnt_mem[cnt_addr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r        <= '0;
      div_cnt_r    <= 1'b0;
      pend_entry_r <= 1'b0;
      pend_blk_r   <= 1'b0;
    end else begin
      if (cmd.clear_step) begin
        clr_r <= clr_r + CLW'(1);
      end
      if (cmd.latch) begin
        div_cnt_r <= 1'b0;
      end else if (cmd.div_step) begin
        div_cnt_r <= !div_cnt_r;
      end
      pend_entry_r <= cmd.scan_step && !whole;
      pend_blk_r   <= cmd.scan_step && whole;
    end
  end

  // Item registers, the divider and the range walk. The division runs in two
  // steps: the quotient first, then the remainder from it.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r  <= in_mode;
      bad_r   <= in_first_pos > in_last_pos;
      empty_r <= (first_x > lim_x) || !v_ok;
      skip_r  <= (first_x >= PRW'(LIMIT)) || !v_ok;
      pos_r   <= first_x;
      lim_r   <= lim_x;
      val_r   <= in_value_id;
      dvd_r   <= in_first_pos;
      rem_r   <= '0;
      q_r     <= '0;
      acc_r   <= '0;
    end else begin
      if (cmd.div_step) begin
        if (div_cnt_r) begin
          rem_r <= RW'(rem_full);
        end else begin
          q_r <= q_div;
        end
      end else if (cmd.scan_step) begin
        if (whole) begin
          pos_r <= pos_r + PRW'(BLOCK_SIZE);
          q_r   <= q_r + POS_W'(1);
        end else begin
          pos_r <= pos_r + PRW'(1);
          if (rem_r == RW'(BLOCK_SIZE - 1)) begin
            rem_r <= '0;
            q_r   <= q_r + POS_W'(1);
          end else begin
            rem_r <= rem_r + RW'(1);
          end
        end
      end
      if (pend_entry_r && vs_rd_r[VAL_W] && (vs_rd_r[VAL_W-1:0] == val_r)) begin
        acc_r <= acc_r + OCC_W'(1);
      end else if (pend_blk_r) begin
        acc_r <= acc_r + OCC_W'(cnt_rd_r);
      end
    end
  end

  always_comb begin
    status.clr_last  = clr_r == CLW'(CLR_LEN - 1);
    status.is_query  = mode_r;
    status.bad       = bad_r;
    status.empty     = empty_r;
    status.upd_skip  = skip_r;
    status.div_last  = div_cnt_r;
    status.scan_done = done;
  end

  assign occurrences = acc_r;
  assign bad_range   = bad_r;

endmodule
`default_nettype wire

// ----- src/rvct_ctrl.sv -----
`default_nettype none
module rvct_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire rvct_pkg::status_t status,
  output rvct_pkg::cmd_t         cmd,
  output logic                   busy,
  output logic                   result_valid
);

  rvct_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rvct_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rvct_pkg::ST_CLEAR: begin
        if (status.clr_last) state_nxt = rvct_pkg::ST_IDLE;
      end
      rvct_pkg::ST_IDLE: begin
        if (start) state_nxt = rvct_pkg::ST_CHECK;
      end
      rvct_pkg::ST_CHECK: begin
        if (status.is_query) begin
          state_nxt = (status.bad || status.empty) ? rvct_pkg::ST_RESULT : rvct_pkg::ST_DIV;
        end else begin
          state_nxt = status.upd_skip ? rvct_pkg::ST_IDLE : rvct_pkg::ST_DIV;
        end
      end
      rvct_pkg::ST_DIV: begin
        if (status.div_last) begin
          state_nxt = status.is_query ? rvct_pkg::ST_SCAN : rvct_pkg::ST_UPD_RDOLD;
        end
      end
      rvct_pkg::ST_SCAN: begin
        if (status.scan_done) state_nxt = rvct_pkg::ST_RESULT;
      end
      rvct_pkg::ST_RESULT:    state_nxt = rvct_pkg::ST_IDLE;
      rvct_pkg::ST_UPD_RDOLD: state_nxt = rvct_pkg::ST_UPD_WROLD;
      rvct_pkg::ST_UPD_WROLD: state_nxt = rvct_pkg::ST_UPD_RDNEW;
      rvct_pkg::ST_UPD_RDNEW: state_nxt = rvct_pkg::ST_UPD_WRNEW;
      rvct_pkg::ST_UPD_WRNEW: state_nxt = rvct_pkg::ST_IDLE;
      default:                state_nxt = rvct_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd          = '0;
    busy         = 1'b1;
    result_valid = 1'b0;
    case (state_r)
      rvct_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
      rvct_pkg::ST_IDLE: begin
        busy      = 1'b0;
        cmd.latch = start;
      end
      rvct_pkg::ST_DIV:       cmd.div_step = 1'b1;
      rvct_pkg::ST_SCAN:      cmd.scan_step = !status.scan_done;
      rvct_pkg::ST_RESULT:    result_valid = 1'b1;
      rvct_pkg::ST_UPD_RDOLD: cmd.sel_old = 1'b1;
      rvct_pkg::ST_UPD_WROLD: begin
        cmd.sel_old = 1'b1;
        cmd.wr_old  = 1'b1;
      end
      rvct_pkg::ST_UPD_WRNEW: cmd.wr_new = 1'b1;
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- src/rvct_checker.sv -----
`default_nettype none
module rvct_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic                       out_valid,
  input wire logic [rvct_pkg::OCC_W-1:0] out_occurrences,
  input wire logic                       out_bad_range
);

  // A result only appears while an item is in work.
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside of work");

  // The strobe lasts a single cycle.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  // An accepted item makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted item left block idle");

  // A reversed range counts nothing.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_range) |-> (out_occurrences == '0))
    else $error("reversed range with nonzero count");

  // No range holds more than 1024 positions.
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_occurrences <= 11'd1024)) else $error("count too large");

endmodule

bind range_value_count_table_top rvct_checker u_rvct_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_occurrences (out_occurrences),
  .out_bad_range   (out_bad_range)
);
`default_nettype wire
